// ===== design/fvu_pkg.sv =====
// ----------------------------------------------------------------------------
// fvu_pkg: shared types and constants of the fly camera view update unit
// Word layouts, fixed-point constants, CORDIC arctangent table and the
// micro-op program that drives the shared multiplier.
// ----------------------------------------------------------------------------
package fvu_pkg;

  // Datapath widths
  localparam int unsigned OpW   = 34;  // multiplier operand, signed
  localparam int unsigned RegW  = 36;  // scratch registers, signed
  localparam int unsigned ModW  = 37;  // yaw reduction, unsigned
  localparam int unsigned CordicSteps = 20;

  typedef logic signed [OpW-1:0]  opnd_t;
  typedef logic signed [RegW-1:0] reg_t;

  // Angles in Q16.16 degrees
  localparam logic signed [31:0] Deg90    = 32'sd5898240;
  localparam logic signed [31:0] Deg180   = 32'sd11796480;
  localparam logic signed [31:0] Deg360   = 32'sd23592960;
  localparam logic signed [31:0] PitchLim = 32'sd5897585;
  localparam logic signed [OpW-1:0] CordicK = 34'sd652032874;
  localparam logic signed [31:0] OneQ16   = 32'sd65536;

  // Item kinds, button codes and register indexes
  localparam logic       KindAxes   = 1'b0;
  localparam logic       KindButton = 1'b1;
  localparam logic [1:0] BtnPos     = 2'd1;
  localparam logic [1:0] BtnAngles  = 2'd2;
  localparam logic       CfgTurn    = 1'b0;
  localparam logic       CfgMove    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [1:0]        button;
    logic [15:0]       dt;
    logic signed [15:0] axis_rx;
    logic signed [15:0] axis_ry;
    logic signed [15:0] axis_lx;
    logic signed [15:0] axis_ly;
    logic signed [15:0] trigger_left;
    logic signed [15:0] trigger_right;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         column;
    logic signed [31:0] elem_x;
    logic signed [31:0] elem_y;
    logic signed [31:0] elem_z;
    logic signed [31:0] elem_w;
    logic               last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_ANGLE, ST_MOD, ST_CORP, ST_WAITP,
    ST_CORY, ST_WAITY, ST_SAT, ST_OUT
  } state_e;

  // Operand and destination codes of the scratch datapath
  typedef enum logic [5:0] {
    OP_RY, OP_RX, OP_LY, OP_LX, OP_TRL, OP_DT, OP_TS, OP_MS, OP_ONE,
    OP_POS0, OP_POS1, OP_POS2,
    OP_PA, OP_YA, OP_M1, OP_M2, OP_M3,
    OP_SP, OP_CP, OP_SY, OP_CY,
    OP_F0, OP_F2, OP_F0H, OP_F1H, OP_F2H,
    OP_UP0, OP_UP1, OP_UP2,
    OP_NP0, OP_NP1, OP_NP2,
    OP_U0, OP_U1, OP_U2,
    OP_SH0, OP_SH2,
    OP_TX, OP_TY, OP_TZ
  } opnd_e;

  // Rounding shift after a product (nearest, ties away from zero)
  typedef enum logic [2:0] {SH_0, SH_14, SH_16, SH_23, SH_30} sh_e;

  // How the rounded product lands in the destination
  typedef enum logic [1:0] {MD_SET, MD_NSET, MD_ADD, MD_SUB} mode_e;

  typedef struct packed {
    opnd_e a;
    opnd_e b;
    sh_e   sh;
    mode_e md;
    opnd_e dst;
  } uop_t;

  typedef struct packed {
    logic  go;
    opnd_t a;
    opnd_t b;
    sh_e   sh;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic  done;
    opnd_t sin_v;
    opnd_t cos_v;
  } cor_res_t;

  // Program phase ends: rates, then vectors and moves, then matrix
  localparam logic [5:0] StepLastA = 6'd9;
  localparam logic [5:0] StepLastB = 6'd29;
  localparam logic [5:0] StepLastC = 6'd46;

  function automatic uop_t uop_at(input logic [5:0] idx);
    uop_t u;
    u = '{OP_ONE, OP_ONE, SH_0, MD_SET, OP_PA};
    unique case (idx)
      // stick times dt
      6'd0:  u = '{OP_RY,  OP_DT,   SH_0,  MD_SET,  OP_PA};
      6'd1:  u = '{OP_RX,  OP_DT,   SH_0,  MD_SET,  OP_YA};
      6'd2:  u = '{OP_LY,  OP_DT,   SH_0,  MD_SET,  OP_M1};
      6'd3:  u = '{OP_LX,  OP_DT,   SH_0,  MD_SET,  OP_M2};
      6'd4:  u = '{OP_TRL, OP_DT,   SH_0,  MD_SET,  OP_M3};
      // times speed
      6'd5:  u = '{OP_PA,  OP_TS,   SH_23, MD_SET,  OP_PA};
      6'd6:  u = '{OP_YA,  OP_TS,   SH_23, MD_SET,  OP_YA};
      6'd7:  u = '{OP_M1,  OP_MS,   SH_23, MD_SET,  OP_M1};
      6'd8:  u = '{OP_M2,  OP_MS,   SH_23, MD_SET,  OP_M2};
      6'd9:  u = '{OP_M3,  OP_MS,   SH_23, MD_SET,  OP_M3};
      // forward vector, f1 is sin pitch
      6'd10: u = '{OP_CP,  OP_CY,   SH_30, MD_SET,  OP_F0};
      6'd11: u = '{OP_CP,  OP_SY,   SH_30, MD_SET,  OP_F2};
      6'd12: u = '{OP_F0,  OP_ONE,  SH_14, MD_SET,  OP_F0H};
      6'd13: u = '{OP_SP,  OP_ONE,  SH_14, MD_SET,  OP_F1H};
      6'd14: u = '{OP_F2,  OP_ONE,  SH_14, MD_SET,  OP_F2H};
      // up = f x right, right = (-f2, 0, f0)
      6'd15: u = '{OP_SP,  OP_F0,   SH_30, MD_SET,  OP_UP0};
      6'd16: u = '{OP_F2,  OP_F2,   SH_30, MD_NSET, OP_UP1};
      6'd17: u = '{OP_F0,  OP_F0,   SH_30, MD_SUB,  OP_UP1};
      6'd18: u = '{OP_SP,  OP_F2,   SH_30, MD_SET,  OP_UP2};
      6'd19: u = '{OP_UP0, OP_ONE,  SH_14, MD_SET,  OP_UP0};
      6'd20: u = '{OP_UP1, OP_ONE,  SH_14, MD_SET,  OP_UP1};
      6'd21: u = '{OP_UP2, OP_ONE,  SH_14, MD_SET,  OP_UP2};
      // position moves
      6'd22: u = '{OP_M1,  OP_F2H,  SH_16, MD_ADD,  OP_NP0};
      6'd23: u = '{OP_M2,  OP_F0H,  SH_16, MD_SUB,  OP_NP0};
      6'd24: u = '{OP_M3,  OP_UP0,  SH_16, MD_ADD,  OP_NP0};
      6'd25: u = '{OP_M2,  OP_F1H,  SH_16, MD_SUB,  OP_NP1};
      6'd26: u = '{OP_M3,  OP_UP1,  SH_16, MD_ADD,  OP_NP1};
      6'd27: u = '{OP_M1,  OP_F0H,  SH_16, MD_SUB,  OP_NP2};
      6'd28: u = '{OP_M2,  OP_F2H,  SH_16, MD_SUB,  OP_NP2};
      6'd29: u = '{OP_M3,  OP_UP2,  SH_16, MD_ADD,  OP_NP2};
      // u = s x f with s = (sy, 0, -cy)
      6'd30: u = '{OP_CY,  OP_SP,   SH_30, MD_SET,  OP_U0};
      6'd31: u = '{OP_CY,  OP_F0,   SH_30, MD_NSET, OP_U1};
      6'd32: u = '{OP_SY,  OP_F2,   SH_30, MD_SUB,  OP_U1};
      6'd33: u = '{OP_SY,  OP_SP,   SH_30, MD_SET,  OP_U2};
      6'd34: u = '{OP_SY,  OP_ONE,  SH_14, MD_SET,  OP_SH0};
      6'd35: u = '{OP_CY,  OP_ONE,  SH_14, MD_NSET, OP_SH2};
      // translation column
      6'd36: u = '{OP_SY,  OP_POS0, SH_30, MD_NSET, OP_TX};
      6'd37: u = '{OP_CY,  OP_POS2, SH_30, MD_ADD,  OP_TX};
      6'd38: u = '{OP_U0,  OP_POS0, SH_30, MD_NSET, OP_TY};
      6'd39: u = '{OP_U1,  OP_POS1, SH_30, MD_SUB,  OP_TY};
      6'd40: u = '{OP_U2,  OP_POS2, SH_30, MD_SUB,  OP_TY};
      6'd41: u = '{OP_F0,  OP_POS0, SH_30, MD_SET,  OP_TZ};
      6'd42: u = '{OP_SP,  OP_POS1, SH_30, MD_ADD,  OP_TZ};
      6'd43: u = '{OP_F2,  OP_POS2, SH_30, MD_ADD,  OP_TZ};
      // u to Q16.16 last, after the dot products used it
      6'd44: u = '{OP_U0,  OP_ONE,  SH_14, MD_SET,  OP_U0};
      6'd45: u = '{OP_U1,  OP_ONE,  SH_14, MD_SET,  OP_U1};
      6'd46: u = '{OP_U2,  OP_ONE,  SH_14, MD_SET,  OP_U2};
      default: u = '{OP_ONE, OP_ONE, SH_0, MD_SET, OP_PA};
    endcase
    return u;
  endfunction

  // CORDIC arctangent of 2^-i in Q16.16 degrees
  function automatic logic [21:0] cordic_atan(input logic [4:0] i);
    logic [21:0] a;
    a = '0;
    unique case (i)
      5'd0:  a = 22'd2949120;
      5'd1:  a = 22'd1740967;
      5'd2:  a = 22'd919879;
      5'd3:  a = 22'd466945;
      5'd4:  a = 22'd234379;
      5'd5:  a = 22'd117304;
      5'd6:  a = 22'd58666;
      5'd7:  a = 22'd29335;
      5'd8:  a = 22'd14668;
      5'd9:  a = 22'd7334;
      5'd10: a = 22'd3667;
      5'd11: a = 22'd1833;
      5'd12: a = 22'd917;
      5'd13: a = 22'd458;
      5'd14: a = 22'd229;
      5'd15: a = 22'd115;
      5'd16: a = 22'd57;
      5'd17: a = 22'd29;
      5'd18: a = 22'd14;
      5'd19: a = 22'd7;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input reg_t v);
    logic signed [31:0] r;
    if (v > reg_t'(32'sh7FFFFFFF)) begin
      r = 32'sh7FFFFFFF;
    end else if (v < reg_t'(-33'sh80000000)) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/fly_camera_view_update_unit.sv =====
// ----------------------------------------------------------------------------
// fly_camera_view_update_unit: fly camera angles, position and view matrix
// Integrates gamepad sticks into pitch, yaw and position, and streams the
// four columns of the look-at view matrix, all in fixed point.
//
//   port group   dir  handshake            word
//   in_*         in   valid / stall        in_word_t: kind, button, dt, axes
//   out_*        out  valid / stall        out_word_t: column, elem_x..w, last
//   cfg_*        in   valid / ready        index 0 turn_speed, 1 move_speed
//
// A button word is taken in the idle state and needs no compute. An axes
// word runs 47 products on the shared multiplier, an 11-step yaw
// reduction and two 20-step CORDIC runs.
// Then four column words leave, one per cycle unless out_stall_i holds them.
// in_stall_o is high from acceptance of an axes word until its last column.
// Reset clears angles and position and loads the default speeds.
// ----------------------------------------------------------------------------
module fly_camera_view_update_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fvu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fvu_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [23:0]        cfg_data_i
);
  import fvu_pkg::*;

  state_e state_q, state_d;

  logic [5:0]  step_q;
  logic [1:0]  col_q;
  logic [3:0]  modk_q;
  logic [ModW-1:0] mod_q;

  logic [23:0] ts_q;
  logic [23:0] ms_q;
  logic signed [31:0] pitch_q;
  logic signed [31:0] yaw_q;
  logic signed [31:0] pos0_q, pos1_q, pos2_q;

  // captured word
  logic signed [15:0] ry_q, rx_q, ly_q, lx_q;
  logic signed [16:0] trl_q;
  logic [15:0]        dt_q;

  // scratch registers
  reg_t pa_q, ya_q, m1_q, m2_q, m3_q;
  reg_t sp_q, cp_q, sy_q, cy_q;
  reg_t f0_q, f2_q, f0h_q, f1h_q, f2h_q;
  reg_t up0_q, up1_q, up2_q;
  reg_t np0_q, np1_q, np2_q;
  reg_t u0_q, u1_q, u2_q;
  reg_t sh0_q, sh2_q;
  reg_t tx_q, ty_q, tz_q;

  logic     in_acc;
  logic     out_acc;
  uop_t     uop;
  mul_req_t mul_req;
  reg_t     mul_res;
  cor_req_t cor_req;
  cor_res_t cor_res;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign uop     = uop_at(step_q);

  // Operand read
  function automatic reg_t rd(input opnd_e o);
    reg_t v;
    v = '0;
    unique case (o)
      OP_RY:   v = reg_t'(ry_q);
      OP_RX:   v = reg_t'(rx_q);
      OP_LY:   v = reg_t'(ly_q);
      OP_LX:   v = reg_t'(lx_q);
      OP_TRL:  v = reg_t'(trl_q);
      OP_DT:   v = reg_t'($signed({1'b0, dt_q}));
      OP_TS:   v = reg_t'($signed({1'b0, ts_q}));
      OP_MS:   v = reg_t'($signed({1'b0, ms_q}));
      OP_ONE:  v = reg_t'(1);
      OP_POS0: v = reg_t'(pos0_q);
      OP_POS1: v = reg_t'(pos1_q);
      OP_POS2: v = reg_t'(pos2_q);
      OP_PA:   v = pa_q;
      OP_YA:   v = ya_q;
      OP_M1:   v = m1_q;
      OP_M2:   v = m2_q;
      OP_M3:   v = m3_q;
      OP_SP:   v = sp_q;
      OP_CP:   v = cp_q;
      OP_SY:   v = sy_q;
      OP_CY:   v = cy_q;
      OP_F0:   v = f0_q;
      OP_F2:   v = f2_q;
      OP_F0H:  v = f0h_q;
      OP_F1H:  v = f1h_q;
      OP_F2H:  v = f2h_q;
      OP_UP0:  v = up0_q;
      OP_UP1:  v = up1_q;
      OP_UP2:  v = up2_q;
      OP_NP0:  v = np0_q;
      OP_NP1:  v = np1_q;
      OP_NP2:  v = np2_q;
      OP_U0:   v = u0_q;
      OP_U1:   v = u1_q;
      OP_U2:   v = u2_q;
      OP_SH0:  v = sh0_q;
      OP_SH2:  v = sh2_q;
      OP_TX:   v = tx_q;
      OP_TY:   v = ty_q;
      OP_TZ:   v = tz_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  reg_t opa_full, opb_full, dst_old, wr_val;

  always_comb begin
    opa_full = rd(uop.a);
    opb_full = rd(uop.b);
    dst_old  = rd(uop.dst);
    unique case (uop.md)
      MD_SET:  wr_val = mul_res;
      MD_NSET: wr_val = -mul_res;
      MD_ADD:  wr_val = dst_old + mul_res;
      MD_SUB:  wr_val = dst_old - mul_res;
      default: wr_val = mul_res;
    endcase
  end

  // Shared multiplier and CORDIC
  fvu_mulrnd u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .res_o (mul_res)
  );

  fvu_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .res_o  (cor_res)
  );

  // Pitch update and yaw reduction arithmetic
  reg_t            p_sum;
  logic signed [31:0] p_new;
  reg_t            y_sum;
  logic [ModW-1:0] mod_init;
  logic [ModW-1:0] mod_sub;
  logic [ModW-1:0] mod_nx;

  always_comb begin
    p_sum = reg_t'(pitch_q) + pa_q;
    if (p_sum > reg_t'(PitchLim)) begin
      p_new = PitchLim;
    end else if (p_sum < reg_t'(-PitchLim)) begin
      p_new = -PitchLim;
    end else begin
      p_new = p_sum[31:0];
    end
    y_sum    = reg_t'(yaw_q) - ya_q;
    mod_init = ModW'(y_sum);
    if (y_sum[RegW-1]) begin
      mod_init = mod_init + (ModW'(Deg360) << 10);
    end
    mod_sub = ModW'(Deg360) << modk_q;
    mod_nx  = (mod_q >= mod_sub) ? (mod_q - mod_sub) : mod_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_word_i.kind == KindAxes)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_ACC;
      ST_ACC: begin
        priority if (step_q == StepLastA) begin
          state_d = ST_ANGLE;
        end else if (step_q == StepLastB) begin
          state_d = ST_SAT;
        end else if (step_q == StepLastC) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_ANGLE: state_d = ST_MOD;
      ST_MOD: begin
        if (modk_q == 4'd0) begin
          state_d = ST_CORP;
        end
      end
      ST_CORP: state_d = ST_WAITP;
      ST_WAITP: begin
        if (cor_res.done) begin
          state_d = ST_CORY;
        end
      end
      ST_CORY: state_d = ST_WAITY;
      ST_WAITY: begin
        if (cor_res.done) begin
          state_d = ST_MUL;
        end
      end
      ST_SAT: state_d = ST_MUL;
      ST_OUT: begin
        if (!out_stall_i && (col_q == 2'd3)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and unit controls
  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    cfg_ready_o   = 1'b1;
    mul_req.go    = (state_q == ST_MUL);
    mul_req.a     = opa_full[OpW-1:0];
    mul_req.b     = opb_full[OpW-1:0];
    mul_req.sh    = uop.sh;
    cor_req.start = (state_q == ST_CORP) || (state_q == ST_CORY);
    cor_req.angle = (state_q == ST_CORP) ? pitch_q : yaw_q;
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      col_q   <= '0;
      modk_q  <= '0;
      ts_q    <= 24'd23040;
      ms_q    <= 24'd1280;
      pitch_q <= '0;
      yaw_q   <= '0;
      pos0_q  <= '0;
      pos1_q  <= '0;
      pos2_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgTurn) begin
          ts_q <= cfg_data_i;
        end else if (cfg_index_i == CfgMove) begin
          ms_q <= cfg_data_i;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          col_q  <= '0;
          if (in_acc && (in_word_i.kind == KindButton)) begin
            if (in_word_i.button == BtnPos) begin
              pos0_q <= '0;
              pos1_q <= '0;
              pos2_q <= '0;
            end else if (in_word_i.button == BtnAngles) begin
              pitch_q <= '0;
              yaw_q   <= '0;
            end
          end
        end
        ST_ACC: step_q <= step_q + 6'd1;
        ST_ANGLE: begin
          pitch_q <= p_new;
          modk_q  <= 4'd10;
        end
        ST_MOD: begin
          if (modk_q == 4'd0) begin
            yaw_q <= mod_nx[31:0];
          end else begin
            modk_q <= modk_q - 4'd1;
          end
        end
        ST_SAT: begin
          pos0_q <= sat32(np0_q);
          pos1_q <= sat32(np1_q);
          pos2_q <= sat32(np2_q);
        end
        ST_OUT: begin
          if (out_acc) begin
            col_q <= col_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Word capture and scratch writes
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_word_i.kind == KindAxes)) begin
      ry_q  <= in_word_i.axis_ry;
      rx_q  <= in_word_i.axis_rx;
      ly_q  <= in_word_i.axis_ly;
      lx_q  <= in_word_i.axis_lx;
      dt_q  <= in_word_i.dt;
      trl_q <= 17'(in_word_i.trigger_right) - 17'(in_word_i.trigger_left);
      np0_q <= reg_t'(pos0_q);
      np1_q <= reg_t'(pos1_q);
      np2_q <= reg_t'(pos2_q);
    end
    if (state_q == ST_ANGLE) begin
      mod_q <= mod_init;
    end else if (state_q == ST_MOD) begin
      mod_q <= mod_nx;
    end
    if ((state_q == ST_WAITP) && cor_res.done) begin
      sp_q <= reg_t'(cor_res.sin_v);
      cp_q <= reg_t'(cor_res.cos_v);
    end
    if ((state_q == ST_WAITY) && cor_res.done) begin
      sy_q <= reg_t'(cor_res.sin_v);
      cy_q <= reg_t'(cor_res.cos_v);
    end
    if (state_q == ST_ACC) begin
      unique case (uop.dst)
        OP_PA:   pa_q  <= wr_val;
        OP_YA:   ya_q  <= wr_val;
        OP_M1:   m1_q  <= wr_val;
        OP_M2:   m2_q  <= wr_val;
        OP_M3:   m3_q  <= wr_val;
        OP_F0:   f0_q  <= wr_val;
        OP_F2:   f2_q  <= wr_val;
        OP_F0H:  f0h_q <= wr_val;
        OP_F1H:  f1h_q <= wr_val;
        OP_F2H:  f2h_q <= wr_val;
        OP_UP0:  up0_q <= wr_val;
        OP_UP1:  up1_q <= wr_val;
        OP_UP2:  up2_q <= wr_val;
        OP_NP0:  np0_q <= wr_val;
        OP_NP1:  np1_q <= wr_val;
        OP_NP2:  np2_q <= wr_val;
        OP_U0:   u0_q  <= wr_val;
        OP_U1:   u1_q  <= wr_val;
        OP_U2:   u2_q  <= wr_val;
        OP_SH0:  sh0_q <= wr_val;
        OP_SH2:  sh2_q <= wr_val;
        OP_TX:   tx_q  <= wr_val;
        OP_TY:   ty_q  <= wr_val;
        OP_TZ:   tz_q  <= wr_val;
        default: ;
      endcase
    end
  end

  // Column word: columns 0..2 are (s, u, -f, 0), column 3 the translation
  reg_t nf0, nf1, nf2;

  always_comb begin
    nf0 = -f0h_q;
    nf1 = -f1h_q;
    nf2 = -f2h_q;
    out_word_o.column = col_q;
    out_word_o.last   = (col_q == 2'd3);
    unique case (col_q)
      2'd0: begin
        out_word_o.elem_x = sh0_q[31:0];
        out_word_o.elem_y = u0_q[31:0];
        out_word_o.elem_z = nf0[31:0];
        out_word_o.elem_w = '0;
      end
      2'd1: begin
        out_word_o.elem_x = '0;
        out_word_o.elem_y = u1_q[31:0];
        out_word_o.elem_z = nf1[31:0];
        out_word_o.elem_w = '0;
      end
      2'd2: begin
        out_word_o.elem_x = sh2_q[31:0];
        out_word_o.elem_y = u2_q[31:0];
        out_word_o.elem_z = nf2[31:0];
        out_word_o.elem_w = '0;
      end
      default: begin
        out_word_o.elem_x = sat32(tx_q);
        out_word_o.elem_y = sat32(ty_q);
        out_word_o.elem_z = sat32(tz_q);
        out_word_o.elem_w = OneQ16;
      end
    endcase
  end

endmodule

// ===== design/fvu_cordic.sv =====
// ----------------------------------------------------------------------------
// fvu_cordic: iterative sine/cosine
// Rotation-mode CORDIC on an angle in Q16.16 degrees, one step per cycle,
// 20 steps, floor shifts. Results are Q2.30.
// ----------------------------------------------------------------------------
module fvu_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvu_pkg::cor_req_t req_i,
  output fvu_pkg::cor_res_t res_o
);
  import fvu_pkg::*;

  localparam logic [4:0] LastStep = 5'(CordicSteps - 1);

  logic               busy_q;
  logic               done_q;
  logic [4:0]         i_q;
  opnd_t              x_q;
  opnd_t              y_q;
  logic signed [31:0] z_q;
  logic               neg_q;

  // Fold the start angle into [-90, 90]
  logic signed [31:0] z_a;
  logic signed [31:0] z_b;
  logic signed [31:0] z_fold;
  logic               neg_fold;

  always_comb begin
    z_a = req_i.angle;
    if (z_a < 0) begin
      z_a = z_a + Deg360;
    end
    z_b = z_a;
    if (z_b >= Deg180) begin
      z_b = z_b - Deg360;
    end
    neg_fold = 1'b0;
    z_fold   = z_b;
    if (z_b > Deg90) begin
      z_fold   = z_b - Deg180;
      neg_fold = 1'b1;
    end else if (z_b < -Deg90) begin
      z_fold   = z_b + Deg180;
      neg_fold = 1'b1;
    end
  end

  // One micro-rotation
  opnd_t              dx;
  opnd_t              dy;
  logic signed [31:0] atan_s;

  always_comb begin
    dx     = x_q >>> i_q;
    dy     = y_q >>> i_q;
    atan_s = $signed({10'b0, cordic_atan(i_q)});
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= busy_q && (i_q == LastStep);
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Vector and residual angle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= CordicK;
      y_q   <= '0;
      z_q   <= z_fold;
      neg_q <= neg_fold;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_q <= x_q - dy;
        y_q <= y_q + dx;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + dy;
        y_q <= y_q - dx;
        z_q <= z_q + atan_s;
      end
    end
  end

  assign res_o.done  = done_q;
  assign res_o.sin_v = neg_q ? -y_q : y_q;
  assign res_o.cos_v = neg_q ? -x_q : x_q;

endmodule

// ===== design/fvu_mulrnd.sv =====
// ----------------------------------------------------------------------------
// fvu_mulrnd: shared multiplier with rounding shift
// Registers a 34x34 signed product, then rounds it to nearest with ties
// away from zero by the requested shift.
// ----------------------------------------------------------------------------
module fvu_mulrnd (
  input  logic              clk_i,
  input  fvu_pkg::mul_req_t req_i,
  output fvu_pkg::reg_t     res_o
);
  import fvu_pkg::*;

  localparam int unsigned PW = 2 * OpW;

  logic signed [PW-1:0] prod_q;
  sh_e                  sh_q;

  // Product register
  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      prod_q <= req_i.a * req_i.b;
      sh_q   <= req_i.sh;
    end
  end

  // Round on magnitude, then restore sign
  logic          neg;
  logic [PW-1:0] mag;
  logic [PW-1:0] half;
  logic [4:0]    shamt;
  logic [PW-1:0] shifted;
  logic [PW-1:0] signed_r;

  always_comb begin
    unique case (sh_q)
      SH_0:    shamt = 5'd0;
      SH_14:   shamt = 5'd14;
      SH_16:   shamt = 5'd16;
      SH_23:   shamt = 5'd23;
      SH_30:   shamt = 5'd30;
      default: shamt = 5'd0;
    endcase
    neg      = prod_q[PW-1];
    mag      = neg ? PW'(-prod_q) : PW'(prod_q);
    half     = (shamt == 5'd0) ? '0 : (PW'(1) << (shamt - 5'd1));
    shifted  = (mag + half) >> shamt;
    signed_r = neg ? -shifted : shifted;
  end

  assign res_o = signed_r[RegW-1:0];

endmodule
